[rtl/dbba_pkg.sv]
package dbba_pkg;

  localparam int SizeBits  = 24;
  localparam int SizeW     = SizeBits + 1;
  localparam int AddrW     = 64;
  localparam int FenceW    = 64;
  localparam int AlignW    = 5;
  localparam int FuncW     = 2;
  localparam int WideW     = 33;
  localparam int SumW      = WideW + 1;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 64;
  localparam int InDataW   = 96;
  localparam int OutDataW  = 120;

  localparam logic [FuncW-1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_BEGIN  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_SUBMIT = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_ENABLED = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BSIZE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BASE0   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_BASE1   = 2'd3;

  localparam logic [SizeW-1:0] SizeCap = SizeW'(1) << SizeBits;

  typedef struct packed {
    logic              enabled;
    logic [SizeW-1:0]  buffer_size;
    logic [AddrW-1:0]  base0;
    logic [AddrW-1:0]  base1;
    logic              clear;
  } cfg_t;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [SizeW-1:0]  request_size;
    logic [AlignW-1:0] alignment_log2;
    logic [FenceW-1:0] fence_value;
  } item_t;

  typedef struct packed {
    logic               granted;
    logic [AddrW-1:0]   grant_address;
    logic [SizeBits-1:0] grant_offset;
    logic               buffer_index;
    logic               fence_pending;
    logic [SizeW-1:0]   remaining_bytes;
  } res_t;

  function automatic logic [WideW-1:0] round_up(input logic [WideW-1:0] v,
                                                input logic [AlignW-1:0] alog);
    logic [WideW-1:0] mask;
    mask = (WideW'(1) << alog) - WideW'(1);
    return (v + mask) & ~mask;
  endfunction

endpackage

[rtl/dbba_cfg.sv]
module dbba_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dbba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dbba_pkg::CfgDataW-1:0] cfg_data_i,
  output dbba_pkg::cfg_t                cfg_o
);
  import dbba_pkg::*;

  logic             enabled_q;
  logic [SizeW-1:0] bsize_q;
  logic [AddrW-1:0] base0_q;
  logic [AddrW-1:0] base1_q;
  logic [SizeW-1:0] bsize_raw;
  logic             wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign bsize_raw   = cfg_data_i[SizeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      bsize_q   <= SizeW'(1);
      base0_q   <= '0;
      base1_q   <= '0;
    end else if (wr) begin
      case (cfg_index_i)
        REG_ENABLED: enabled_q <= cfg_data_i[0];
        REG_BSIZE:   bsize_q   <= (bsize_raw > SizeCap) ? SizeCap : bsize_raw;
        REG_BASE0:   base0_q   <= cfg_data_i;
        REG_BASE1:   base1_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // enable write restarts the allocator state
  assign cfg_o.enabled     = enabled_q;
  assign cfg_o.buffer_size = bsize_q;
  assign cfg_o.base0       = base0_q;
  assign cfg_o.base1       = base1_q;
  assign cfg_o.clear       = wr && (cfg_index_i == REG_ENABLED);

endmodule

[rtl/dbba_core.sv]
module dbba_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dbba_pkg::cfg_t  cfg_i,
  input  logic            fire_i,
  input  dbba_pkg::item_t item_i,
  output dbba_pkg::res_t  res_o
);
  import dbba_pkg::*;

  logic              cur_q, cur_d;
  logic [SizeW-1:0]  head_q, head_d;
  logic [FenceW-1:0] fence_q [2];
  logic              fence_we;

  logic [WideW-1:0]  ahead, asize;
  logic [SumW-1:0]   span;
  logic              req_ok, fits, wrap_ok;
  logic [AddrW-1:0]  base;
  logic [FenceW-1:0] next_fence;

  assign req_ok  = (item_i.request_size != '0) && (item_i.request_size <= cfg_i.buffer_size);
  assign ahead   = round_up(WideW'(head_q), item_i.alignment_log2);
  assign asize   = round_up(WideW'(item_i.request_size), item_i.alignment_log2);
  assign span    = SumW'(ahead) + SumW'(asize);
  assign fits    = span <= SumW'(cfg_i.buffer_size);
  assign wrap_ok = asize <= WideW'(cfg_i.buffer_size);
  assign base    = cur_q ? cfg_i.base1 : cfg_i.base0;
  assign next_fence = fence_q[~cur_q];

  always_comb begin
    cur_d                 = cur_q;
    head_d                = head_q;
    fence_we              = 1'b0;
    res_o.granted         = 1'b0;
    res_o.grant_address   = '0;
    res_o.grant_offset    = '0;
    res_o.fence_pending   = 1'b0;
    if (cfg_i.enabled) begin
      case (item_i.func)
        FUNC_ALLOC: begin
          if (req_ok && fits) begin
            res_o.granted       = 1'b1;
            res_o.grant_offset  = ahead[SizeBits-1:0];
            res_o.grant_address = base + AddrW'(ahead);
            head_d              = span[SizeW-1:0];
          end else if (req_ok && wrap_ok) begin
            res_o.granted       = 1'b1;
            res_o.grant_address = base;
            head_d              = asize[SizeW-1:0];
          end
        end
        FUNC_BEGIN: begin
          res_o.fence_pending = (next_fence != '0) && (next_fence > item_i.fence_value);
          cur_d               = ~cur_q;
          head_d              = '0;
        end
        FUNC_SUBMIT: fence_we = 1'b1;
        default: ;
      endcase
    end
    res_o.buffer_index    = cur_d;
    res_o.remaining_bytes = (!cfg_i.enabled || head_d >= cfg_i.buffer_size) ? '0 :
                            cfg_i.buffer_size - head_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= 1'b0;
      head_q     <= '0;
      fence_q[0] <= '0;
      fence_q[1] <= '0;
    end else if (cfg_i.clear) begin
      cur_q      <= 1'b0;
      head_q     <= '0;
      fence_q[0] <= '0;
      fence_q[1] <= '0;
    end else if (fire_i) begin
      cur_q  <= cur_d;
      head_q <= head_d;
      if (fence_we) begin
        fence_q[cur_q] <= item_i.fence_value;
      end
    end
  end

endmodule

[rtl/double_buffered_bump_allocator_unit.sv]
// Frame scratch allocator over two equal buffers.
// Request channel s_axis: tuser carries the function (allocate, begin frame,
// submit frame); tdata carries request size, alignment exponent and fence.
// Result channel m_axis: one result per request, in order.
// Configuration channel cfg: index/data writes, always ready; write only while
// no request is in flight. Writing the enable register restarts the buffers.
// An accepted request is held in the request register, its result in the result
// register. Throughput: one request per cycle while m_axis_tready is high. The
// head update (round up, add, compare against buffer size) is combinational, so
// back-to-back allocations chain through the head register without bubbles.
// Stalls: a request register and a result register form a two-deep pipeline;
// when m_axis_tready is low both fill and s_axis_tready drops only once the
// request register is also full.
// Reset: disabled, buffer size 1, base addresses 0, buffer 0, head 0, fences 0;
// both pipeline stages empty.
module double_buffered_bump_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [24:0] request_size, [29:25] alignment_log2, [93:30] fence_value
  input  logic [dbba_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] func
  input  logic [dbba_pkg::FuncW-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] granted, [64:1] grant_address, [88:65] grant_offset, [89] buffer_index,
  // [90] fence_pending, [115:91] remaining_bytes
  output logic [dbba_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dbba_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dbba_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dbba_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  in_vld_q, out_vld_q;
  logic  advance, fire;

  dbba_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dbba_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (res)
  );

  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.func           <= s_axis_tuser;
      item_q.request_size   <= s_axis_tdata[24:0];
      item_q.alignment_log2 <= s_axis_tdata[29:25];
      item_q.fence_value    <= s_axis_tdata[93:30];
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, res_q.remaining_bytes, res_q.fence_pending,
                          res_q.buffer_index, res_q.grant_offset,
                          res_q.grant_address, res_q.granted};

  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(item_q))
    else $error("pending request lost or changed");

  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("processed request produced no result");

  a_grant_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.granted |-> !res_q.fence_pending)
    else $error("grant and fence flag together");

  a_nogrant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.granted |-> res_q.grant_address == '0 && res_q.grant_offset == '0)
    else $error("failed request carries an address");

endmodule

[test/dbba_checker.sv]
module dbba_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic [dbba_pkg::InDataW-1:0]  req_data_i,
  input  logic [dbba_pkg::FuncW-1:0]    req_func_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [dbba_pkg::OutDataW-1:0] res_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [dbba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dbba_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          end_check_i,
  output int                            open_o,
  output int                            errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dbba_pkg::*;

  localparam int OffLo   = AddrW + 1;
  localparam int BidxPos = OffLo + SizeBits;
  localparam int FpPos   = BidxPos + 1;
  localparam int RemLo   = FpPos + 1;

  logic             en;
  logic [SizeW-1:0] bsize;
  logic [AddrW-1:0] base0;
  logic [AddrW-1:0] base1;
  logic             cur;
  logic [SizeW-1:0] head;
  logic [FenceW-1:0] fences [2];

  res_t owed_results [$];
  int   n_err = 0;
  bit   ended = 1'b0;

  assign open_o   = owed_results.size();
  assign errors_o = n_err;

  task automatic flag(input string field, input logic [63:0] got, input logic [63:0] want);
    if (n_err < 60) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
    end
    n_err++;
  endtask

  function automatic logic [63:0] align_up(input logic [63:0] v, input logic [63:0] a);
    return (v + a - 64'd1) & ~(a - 64'd1);
  endfunction

  function automatic res_t alloc_outcome(input item_t it);
    res_t        r;
    logic [63:0] a;
    logic [63:0] ahead;
    logic [63:0] asize;
    logic [63:0] sel;
    logic [63:0] pf;
    logic        nxt;
    r = '0;
    if (en) begin
      case (it.func)
        FUNC_ALLOC: begin
          a = 64'd1 << it.alignment_log2;
          if (it.request_size != '0 && it.request_size <= bsize) begin
            ahead = align_up(64'(head), a);
            asize = align_up(64'(it.request_size), a);
            sel   = cur ? base1 : base0;
            if (ahead + asize > 64'(bsize)) begin
              if (asize <= 64'(bsize)) begin
                r.granted       = 1'b1;
                r.grant_address = sel;
                r.grant_offset  = '0;
                head            = SizeW'(asize);
              end
            end else begin
              r.granted       = 1'b1;
              r.grant_address = sel + ahead;
              r.grant_offset  = SizeBits'(ahead);
              head            = SizeW'(ahead + asize);
            end
          end
        end
        FUNC_BEGIN: begin
          nxt             = ~cur;
          pf              = fences[nxt];
          r.fence_pending = (pf != '0) && (pf > it.fence_value);
          cur             = nxt;
          head            = '0;
        end
        FUNC_SUBMIT: begin
          fences[cur] = it.fence_value;
        end
        default: ;
      endcase
      r.remaining_bytes = (head >= bsize) ? '0 : bsize - head;
    end
    r.buffer_index = cur;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    res_t  got;
    res_t  want;
    if (!rst_ni) begin
      en        = 1'b0;
      bsize     = SizeW'(1);
      base0     = '0;
      base1     = '0;
      cur       = 1'b0;
      head      = '0;
      fences[0] = '0;
      fences[1] = '0;
      owed_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ENABLED: begin
            en        = cfg_data_i[0];
            cur       = 1'b0;
            head      = '0;
            fences[0] = '0;
            fences[1] = '0;
          end
          REG_BSIZE: begin
            bsize = (cfg_data_i[SizeW-1:0] > SizeCap) ? SizeCap : cfg_data_i[SizeW-1:0];
          end
          REG_BASE0: base0 = cfg_data_i;
          REG_BASE1: base1 = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        got.granted         = res_data_i[0];
        got.grant_address   = res_data_i[AddrW:1];
        got.grant_offset    = res_data_i[BidxPos-1:OffLo];
        got.buffer_index    = res_data_i[BidxPos];
        got.fence_pending   = res_data_i[FpPos];
        got.remaining_bytes = res_data_i[RemLo+SizeW-1:RemLo];
        if (owed_results.size() == 0) begin
          flag("unexpected result", 64'(got.granted), 64'd0);
        end else begin
          want = owed_results.pop_front();
          if (got.granted !== want.granted)
            flag("granted", 64'(got.granted), 64'(want.granted));
          if (got.grant_address !== want.grant_address)
            flag("grant_address", got.grant_address, want.grant_address);
          if (got.grant_offset !== want.grant_offset)
            flag("grant_offset", 64'(got.grant_offset), 64'(want.grant_offset));
          if (got.buffer_index !== want.buffer_index)
            flag("buffer_index", 64'(got.buffer_index), 64'(want.buffer_index));
          if (got.fence_pending !== want.fence_pending)
            flag("fence_pending", 64'(got.fence_pending), 64'(want.fence_pending));
          if (got.remaining_bytes !== want.remaining_bytes)
            flag("remaining_bytes", 64'(got.remaining_bytes), 64'(want.remaining_bytes));
        end
      end
      if (req_valid_i && req_ready_i) begin
        it.func           = req_func_i;
        it.request_size   = req_data_i[SizeW-1:0];
        it.alignment_log2 = req_data_i[SizeW+AlignW-1:SizeW];
        it.fence_value    = req_data_i[SizeW+AlignW+FenceW-1:SizeW+AlignW];
        owed_results.push_back(alloc_outcome(it));
      end
      if (end_check_i && !ended) begin
        ended = 1'b1;
        if (owed_results.size() != 0) begin
          flag("results never returned", 64'(owed_results.size()), 64'd0);
        end
      end
    end
  end

endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dbba_pkg::*;

  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;
  localparam int STUCK_LIMIT = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [FuncW-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                end_check;

  int               open_cnt;
  int               err_cnt;
  int               idle_pct = 0;
  int               stall_pct = 0;
  bit               hold_go = 1'b0;
  logic [SizeW-1:0] bsize_now = SizeW'(1);
  int               stuck = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  double_buffered_bump_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  dbba_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_func_i  (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .end_check_i (end_check),
    .open_o      (open_cnt),
    .errors_o    (err_cnt)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // result side: random stall, or a long hold-off on request
  initial begin
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        hold    = 80;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send(input logic [FuncW-1:0] f, input logic [SizeW-1:0] sz,
                      input logic [AlignW-1:0] al, input logic [FenceW-1:0] fv);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser  = f;
    s_axis_tdata  = InDataW'({fv, al, sz});
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (open_cnt != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    drain();
    repeat (3) @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == REG_BSIZE) begin
      bsize_now = (val[SizeW-1:0] > SizeCap) ? SizeCap : val[SizeW-1:0];
    end
  endtask

  task automatic send_random();
    int               k;
    int               lim;
    logic [FuncW-1:0] f;
    logic [SizeW-1:0] sz;
    logic [AlignW-1:0] al;
    logic [FenceW-1:0] fv;
    lim = (bsize_now == '0) ? 1 : int'(bsize_now);
    k = $urandom_range(0, 99);
    if (k < 72) f = FUNC_ALLOC;
    else if (k < 84) f = FUNC_BEGIN;
    else if (k < 96) f = FUNC_SUBMIT;
    else f = FUNC_UNUSED;
    k = $urandom_range(0, 19);
    if (k == 0) sz = '0;
    else if (k == 1) sz = SizeW'($urandom);
    else if (k == 2) sz = SizeW'(lim);
    else if (k < 10) sz = SizeW'($urandom_range(1, (lim / 4 > 1) ? lim / 4 : 1));
    else sz = SizeW'($urandom_range(1, (lim / 32 > 1) ? lim / 32 : 1));
    if ($urandom_range(0, 9) == 0) al = AlignW'($urandom_range(0, 31));
    else al = AlignW'($urandom_range(0, 6));
    if ($urandom_range(0, 4) == 0) fv = {$urandom, $urandom};
    else fv = FenceW'($urandom_range(0, 12));
    send(f, sz, al, fv);
  endtask

  initial begin
    int n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_ALLOC;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_ENABLED;
    cfg_data_i    = '0;
    end_check     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // still disabled
    send(FUNC_ALLOC, 25'd16, 5'd0, 64'd0);
    send(FUNC_BEGIN, 25'd0, 5'd0, 64'd7);
    send(FUNC_SUBMIT, 25'd0, 5'd0, 64'd9);

    write_reg(REG_ENABLED, 64'd1);
    write_reg(REG_BSIZE, 64'd256);
    write_reg(REG_BASE0, 64'hFFFF_FFFF_FFFF_FF00);
    write_reg(REG_BASE1, 64'h0000_0001_0000_0000);
    send(FUNC_ALLOC, 25'd0, 5'd0, 64'd0);
    send(FUNC_ALLOC, 25'd257, 5'd0, 64'd0);
    send(FUNC_ALLOC, 25'h1FF_FFFF, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
    send(FUNC_ALLOC, 25'd1, 5'd0, 64'd0);
    send(FUNC_ALLOC, 25'd3, 5'd2, 64'd0);
    send(FUNC_ALLOC, 25'd100, 5'd9, 64'd0);
    send(FUNC_ALLOC, 25'd200, 5'd3, 64'd0);
    send(FUNC_ALLOC, 25'd100, 5'd4, 64'd0);
    send(FUNC_ALLOC, 25'd256, 5'd0, 64'd0);
    send(FUNC_SUBMIT, 25'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(FUNC_BEGIN, 25'd0, 5'd0, 64'd5);
    send(FUNC_SUBMIT, 25'd0, 5'd0, 64'd10);
    send(FUNC_BEGIN, 25'd0, 5'd0, 64'd3);
    send(FUNC_ALLOC, 25'd64, 5'd6, 64'd0);
    send(FUNC_ALLOC, 25'd64, 5'd6, 64'd0);
    send(FUNC_ALLOC, 25'd128, 5'd0, 64'd0);
    send(FUNC_BEGIN, 25'd0, 5'd0, 64'd9);
    send(FUNC_BEGIN, 25'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(FUNC_UNUSED, 25'h0AA_AAAA, 5'd21, 64'h5555_5555_5555_5555);
    send(FUNC_ALLOC, 25'd200, 5'd0, 64'd0);
    // shrink below the head
    write_reg(REG_BSIZE, 64'd100);
    send(FUNC_UNUSED, 25'd0, 5'd0, 64'd0);
    send(FUNC_ALLOC, 25'd1, 5'd0, 64'd0);
    write_reg(REG_BSIZE, 64'd0);
    send(FUNC_ALLOC, 25'd1, 5'd0, 64'd0);
    write_reg(REG_BSIZE, 64'hFFFF_FFFF_FFFF_FFFF);
    send(FUNC_ALLOC, 25'h100_0000, 5'd24, 64'd0);

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin
          write_reg(REG_ENABLED, 64'd1);
          write_reg(REG_BSIZE, 64'd4096);
          write_reg(REG_BASE0, {$urandom, $urandom});
          write_reg(REG_BASE1, {$urandom, $urandom});
        end
        1: write_reg(REG_BSIZE, 64'd64);
        2: begin
          write_reg(REG_BSIZE, {$urandom, $urandom} | 64'h100_0001);
          write_reg(REG_BASE1, 64'hFFFF_FFFF_FFFF_FFFF);
        end
        3: write_reg(REG_BSIZE, 64'd1);
        4: begin
          write_reg(REG_ENABLED, {$urandom, $urandom} | 64'd1);
          write_reg(REG_BSIZE, 64'd256);
        end
        5: write_reg(REG_BSIZE, 64'd0);
        6: write_reg(REG_ENABLED, {$urandom, $urandom} & ~64'd1);
        7: begin
          write_reg(REG_ENABLED, 64'd1);
          write_reg(REG_BSIZE, 64'($urandom_range(1, 65536)));
          write_reg(REG_BASE0, 64'd0);
        end
        default: begin
          write_reg(REG_BSIZE, 64'd1024);
          write_reg(REG_BASE1, {$urandom, $urandom});
        end
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      n = (p == 6) ? 40 : 180;
      for (int i = 0; i < n; i++) begin
        if (p == 2 && i == 0) hold_go = 1'b1;
        if (p == 1 && i == n / 2) drain();
        send_random();
      end
    end

    drain();
    repeat (5) @(negedge clk_i);
    end_check = 1'b1;
    @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dbba_pkg.sv
rtl/dbba_cfg.sv
rtl/dbba_core.sv
rtl/double_buffered_bump_allocator_unit.sv
test/dbba_checker.sv
test/tb_top.sv
